>>> sv/ssm_pkg.sv
// Shared constants, register codes and types for the streaming substring matcher.
package ssm_pkg;

    localparam int PATTERN_MAX   = 8;
    localparam int POSITION_BITS = 16;

    localparam int BYTE_W     = 8;
    localparam int WIN_W      = PATTERN_MAX * BYTE_W;
    localparam int CFG_PAT_W  = 64;
    localparam int LEN_W      = 4;
    localparam int SEEN_W     = $clog2(PATTERN_MAX + 1);
    localparam int START_W    = 16;
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 4;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    // Register index, taken from paddr[3] (registers sit 8 bytes apart)
    typedef enum logic [0:0] {
        REG_PATTERN_BYTES  = 1'b0,
        REG_PATTERN_LENGTH = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_PAT_W-1:0] pat_bytes;
        logic [LEN_W-1:0]     pat_len;
    } t_pattern_cfg;

    typedef struct packed {
        logic                     found;
        logic [POSITION_BITS-1:0] start;
    } t_match_res;

endpackage

>>> sv/ssm_cfg_regs.sv
// APB register file holding the pattern bytes and the pattern length.
module ssm_cfg_regs
    import ssm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_pattern_cfg          o_cfg
);

    logic [CFG_PAT_W-1:0] r_pat_bytes;
    logic [LEN_W-1:0]     r_pat_len;
    logic                 wr_en;
    t_reg_idx             reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = t_reg_idx'(paddr[3]);

    // Write the addressed register on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_bytes <= '0;
            r_pat_len   <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_PATTERN_BYTES:  r_pat_bytes <= pwdata[CFG_PAT_W-1:0];
                REG_PATTERN_LENGTH: r_pat_len   <= pwdata[LEN_W-1:0];
                default:            ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            REG_PATTERN_BYTES:  prdata = APB_DATA_W'(r_pat_bytes);
            REG_PATTERN_LENGTH: prdata = APB_DATA_W'(r_pat_len);
            default:            prdata = '0;
        endcase
    end

    assign o_cfg.pat_bytes = r_pat_bytes;
    assign o_cfg.pat_len   = r_pat_len;

endmodule

>>> sv/ssm_match_core.sv
// Byte window, pattern compare and first-match latch for one text.
module ssm_match_core
    import ssm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [BYTE_W-1:0] i_text_byte,
    input  logic              i_text_start,
    input  t_pattern_cfg      i_cfg,
    output t_match_res        o_res
);

    logic [WIN_W-1:0]         r_window;
    logic [SEEN_W-1:0]        r_seen;
    logic [POSITION_BITS-1:0] r_pos;
    logic                     r_found;
    logic [POSITION_BITS-1:0] r_found_pos;

    logic [WIN_W-1:0]         n_window;
    logic [SEEN_W-1:0]        n_seen;
    logic [POSITION_BITS-1:0] n_pos;
    logic                     n_found;
    logic [POSITION_BITS-1:0] n_found_pos;

    logic [WIN_W-1:0]         win_base;
    logic [SEEN_W-1:0]        seen_base;
    logic [POSITION_BITS-1:0] pos_cur;
    logic                     found_base;
    logic [POSITION_BITS-1:0] found_pos_base;
    logic                     hit;
    logic                     len_ok;

    // Clear the search when a new text starts
    always_comb begin
        win_base       = i_text_start ? '0 : r_window;
        seen_base      = i_text_start ? '0 : r_seen;
        pos_cur        = i_text_start ? '0 : r_pos;
        found_base     = i_text_start ? 1'b0 : r_found;
        found_pos_base = i_text_start ? '0 : r_found_pos;
    end

    // Shift the byte in, advance the saturating counters
    always_comb begin
        n_window = {win_base[WIN_W-BYTE_W-1:0], i_text_byte};
        n_seen   = (seen_base < SEEN_W'(PATTERN_MAX)) ? seen_base + 1'b1 : seen_base;
        n_pos    = (pos_cur < POS_MAX) ? pos_cur + 1'b1 : pos_cur;
    end

    // Compare the newest bytes against the pattern, one lane per length
    always_comb begin
        int k;
        hit = 1'b0;
        for (int l = 1; l <= PATTERN_MAX; l++) begin
            len_ok = (i_cfg.pat_len == LEN_W'(l)) && (n_seen >= SEEN_W'(l));
            for (int i = 0; i < PATTERN_MAX; i++) begin
                k = l - 1 - i;
                if (i < l) begin
                    if (i_cfg.pat_bytes[i*BYTE_W +: BYTE_W] != n_window[k*BYTE_W +: BYTE_W])
                        len_ok = 1'b0;
                end
            end
            hit = hit | len_ok;
        end
    end

    // Latch the first match of the text
    always_comb begin
        n_found     = found_base;
        n_found_pos = found_pos_base;
        if (!found_base && hit) begin
            n_found     = 1'b1;
            n_found_pos = pos_cur + POSITION_BITS'(1)
                          - {{(POSITION_BITS-LEN_W){1'b0}}, i_cfg.pat_len};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= '0;
            r_seen      <= '0;
            r_pos       <= '0;
            r_found     <= 1'b0;
            r_found_pos <= '0;
        end else if (i_fire) begin
            r_window    <= n_window;
            r_seen      <= n_seen;
            r_pos       <= n_pos;
            r_found     <= n_found;
            r_found_pos <= n_found_pos;
        end
    end

    assign o_res.found = n_found;
    assign o_res.start = n_found ? n_found_pos : '0;

endmodule

>>> sv/streaming_substring_matcher.sv
// Streaming substring matcher: one text byte per request is taken at s_*, one
// result per byte leaves at m_*. A byte and a result both move at the rate of one
// per clock while m_tready stays high; a byte is held in the input register when
// accepted and its result is loaded into the result register once it is free.
// While a result waits, one further byte is taken into the input register before
// s_tready drops. The pattern (up to 8 bytes, first byte lowest) and its length
// are set over APB at byte addresses 0 and 8; the user must set them only while
// the stream is idle, which the block does not enforce. Length 0 or above 8
// never matches. m_tuser flags that the pattern has occurred in the current text
// and m_tdata then holds the index of the first matched byte (zero otherwise).
module streaming_substring_matcher
    import ssm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] text_byte
    input  logic                  s_tuser,   // [0] text_start
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [15:0] match_start
    output logic                  m_tuser,   // [0] match_found
    // Configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_pattern_cfg       cfg;
    t_match_res         res;

    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;
    logic               r_in_start;
    logic               r_out_valid;
    logic               r_out_found;
    logic [START_W-1:0] r_out_start;

    logic               out_free;
    logic               core_fire;
    logic               in_take;

    assign out_free  = !r_out_valid || m_tready;
    assign core_fire = r_in_valid && out_free;
    assign s_tready  = !r_in_valid || out_free;
    assign in_take   = s_tvalid && s_tready;

    ssm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ssm_match_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (core_fire),
        .i_text_byte  (r_in_byte),
        .i_text_start (r_in_start),
        .i_cfg        (cfg),
        .o_res        (res)
    );

    // Hold the accepted request until the core takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte  <= s_tdata;
            r_in_start <= s_tuser;
        end
    end

    // Result register: load on core advance, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= core_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_fire) begin
            r_out_found <= res.found;
            r_out_start <= START_W'(res.start);
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out_found;
    assign m_tdata  = r_out_start;

endmodule

>>> sv/ssm_checker.sv
// Port-level checks for the streaming substring matcher, bound to the top level.
module ssm_checker
    import ssm_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    // A stalled result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // No match means a zero start index
    a_zero_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser |-> m_tdata == 16'd0)
        else $error("start index set without a match");

    // An empty result register never blocks the input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with result register empty");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind streaming_substring_matcher ssm_checker u_ssm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
